FILE: rtl/core/value_range_monitor_watchdog_unit_assert.svh
// Assertion macros shared by the checker of the value range monitor.
// No dependencies; included by the files that assert.
`ifndef VALUE_RANGE_MONITOR_WATCHDOG_UNIT_ASSERT_SVH
`define VALUE_RANGE_MONITOR_WATCHDOG_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define VRMW_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("vrmw assertion failed");

// Property checked on every clock edge, reset included.
`define VRMW_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("vrmw assertion failed");

`endif

FILE: rtl/core/vrmw_pkg.sv
// Package of the value range monitor: codes, register indexes and shared types.
// No dependencies; used by every design module of the block.
`default_nettype none

package vrmw_pkg;

  localparam logic [1:0] OP_VALUE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [2:0] ALARM_NONE    = 3'd0;
  localparam logic [2:0] ALARM_LOW     = 3'd1;
  localparam logic [2:0] ALARM_HIGH    = 3'd2;
  localparam logic [2:0] ALARM_WAIT    = 3'd3;
  localparam logic [2:0] ALARM_TIMEOUT = 3'd4;

  localparam logic [1:0] PH_OFF        = 2'd0;
  localparam logic [1:0] PH_WAIT_VALUE = 2'd1;
  localparam logic [1:0] PH_WAIT_REPLY = 2'd2;

  localparam logic [1:0] LM_OFF   = 2'd0;
  localparam logic [1:0] LM_FLAG  = 2'd1;
  localparam logic [1:0] LM_LAST  = 2'd2;
  localparam logic [1:0] LM_LIMIT = 2'd3;

  localparam logic [1:0] RT_REPL_TO_INPUT = 2'd0;
  localparam logic [1:0] RT_VALID_OUT     = 2'd1;
  localparam logic [1:0] RT_BOTH_OUT      = 2'd2;

  localparam logic [1:0] WD_ALARM      = 2'd0;
  localparam logic [1:0] WD_READ       = 2'd1;
  localparam logic [1:0] WD_READ_FALLB = 2'd2;
  localparam logic [1:0] WD_FALLBACK   = 2'd3;

  localparam int unsigned CfgIdxWidth = 3;
  localparam logic [CfgIdxWidth-1:0] REG_LOW_MODE       = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_HIGH_MODE      = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_LOW_LIMIT      = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_HIGH_LIMIT     = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_ROUTE_MODE     = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_WATCHDOG_MODE  = 3'd5;
  localparam logic [CfgIdxWidth-1:0] REG_TIMEOUT_TICKS  = 3'd6;
  localparam logic [CfgIdxWidth-1:0] REG_FALLBACK_VALUE = 3'd7;

  localparam logic [31:0] REPLY_TIMEOUT_TICKS = 32'd5000;

  typedef struct packed {
    logic [1:0]         low_mode;
    logic [1:0]         high_mode;
    logic signed [63:0] low_limit;
    logic signed [63:0] high_limit;
    logic [1:0]         route_mode;
    logic [1:0]         watchdog_mode;
    logic [31:0]        timeout_ticks;
    logic signed [63:0] fallback_value;
  } cfg_t;

  typedef struct packed {
    logic lo;
    logic hi;
    logic ok;
    logic watch;
  } range_t;

  typedef struct packed {
    logic               send_valid;
    logic               send_to_input;
    logic signed [63:0] sent_value;
    logic               sent_replacement;
    logic               too_low;
    logic               too_high;
    logic               summary_alarm;
    logic               receive_timeout;
    logic               read_request;
    logic [2:0]         alarm_code;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/vrmw_cfg_regs.sv
// Configuration register file of the value range monitor.
// Depends on vrmw_pkg for the register indexes and the cfg_t type.
`default_nettype none

module vrmw_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               wr_en_i,
  input  wire logic [vrmw_pkg::CfgIdxWidth-1:0]   wr_index_i,
  input  wire logic [63:0]                        wr_data_i,
  output vrmw_pkg::cfg_t                          cfg_o
);

  vrmw_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        vrmw_pkg::REG_LOW_MODE:       cfg_d.low_mode       = wr_data_i[1:0];
        vrmw_pkg::REG_HIGH_MODE:      cfg_d.high_mode      = wr_data_i[1:0];
        vrmw_pkg::REG_LOW_LIMIT:      cfg_d.low_limit      = wr_data_i;
        vrmw_pkg::REG_HIGH_LIMIT:     cfg_d.high_limit     = wr_data_i;
        vrmw_pkg::REG_ROUTE_MODE:     cfg_d.route_mode     = wr_data_i[1:0];
        vrmw_pkg::REG_WATCHDOG_MODE:  cfg_d.watchdog_mode  = wr_data_i[1:0];
        vrmw_pkg::REG_TIMEOUT_TICKS:  cfg_d.timeout_ticks  = wr_data_i[31:0];
        vrmw_pkg::REG_FALLBACK_VALUE: cfg_d.fallback_value = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/vrmw_range_check.sv
// Limit comparison of one received value against the configured low and high limits.
// Depends on vrmw_pkg for the cfg_t and range_t types.
`default_nettype none

module vrmw_range_check (
  input  wire logic signed [63:0] sample_i,
  input  vrmw_pkg::cfg_t          cfg_i,
  output vrmw_pkg::range_t        range_o
);

  logic low_on, high_on;

  assign low_on  = (cfg_i.low_mode != vrmw_pkg::LM_OFF);
  assign high_on = (cfg_i.high_mode != vrmw_pkg::LM_OFF);

  always_comb begin
    range_o.lo    = low_on && ($signed(sample_i) < $signed(cfg_i.low_limit));
    range_o.hi    = high_on && ($signed(sample_i) > $signed(cfg_i.high_limit));
    range_o.ok    = !range_o.lo && !range_o.hi;
    range_o.watch = low_on || high_on || (cfg_i.timeout_ticks != 32'd0);
  end

endmodule

`default_nettype wire

FILE: rtl/core/vrmw_core.sv
// Monitor state, watchdog and send routing; computes one result per item.
// Depends on vrmw_pkg and on vrmw_range_check for the limit comparison.
`default_nettype none

module vrmw_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [63:0] sample_i,
  input  vrmw_pkg::cfg_t          cfg_i,
  output vrmw_pkg::result_t       result_o
);

  vrmw_pkg::range_t rng;

  logic [1:0]         phase_q, phase_d;
  logic [31:0]        elapsed_q, elapsed_d;
  logic signed [63:0] last_good_q, last_good_d;
  logic               has_good_q, has_good_d;
  logic [2:0]         alarm_q, alarm_d;
  logic               low_q, low_d;
  logic               high_q, high_d;
  logic               summary_q, summary_d;
  logic               timeout_q, timeout_d;
  logic               seen_q, seen_d;

  logic               armed;
  logic               tmo_on;
  logic               wd_reads;
  logic [31:0]        elapsed_inc;
  logic               raise_alarm;
  logic               use_fallback;
  logic               rd;
  logic               em_req;
  logic               em_good;
  logic signed [63:0] em_val;
  logic [1:0]         repl_mode;
  logic               go;
  logic               to_in;
  logic               send;

  vrmw_range_check u_range_check (
    .sample_i (sample_i),
    .cfg_i    (cfg_i),
    .range_o  (rng)
  );

  assign armed    = (phase_q == vrmw_pkg::PH_WAIT_VALUE) || (phase_q == vrmw_pkg::PH_WAIT_REPLY);
  assign tmo_on   = (cfg_i.timeout_ticks != 32'd0);
  assign wd_reads = (cfg_i.watchdog_mode == vrmw_pkg::WD_READ) ||
                    (cfg_i.watchdog_mode == vrmw_pkg::WD_READ_FALLB);
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
  assign repl_mode   = rng.lo ? cfg_i.low_mode : cfg_i.high_mode;

  always_comb begin
    phase_d      = phase_q;
    elapsed_d    = elapsed_q;
    last_good_d  = last_good_q;
    has_good_d   = has_good_q;
    alarm_d      = alarm_q;
    low_d        = low_q;
    high_d       = high_q;
    summary_d    = summary_q;
    timeout_d    = timeout_q;
    seen_d       = seen_q;
    raise_alarm  = 1'b0;
    use_fallback = 1'b0;
    rd           = 1'b0;
    em_req       = 1'b0;
    em_good      = 1'b0;
    em_val       = '0;
    case (op_i)
      vrmw_pkg::OP_VALUE: begin
        seen_d = 1'b1;
        if (tmo_on) begin
          if (armed) begin
            elapsed_d = '0;
            phase_d   = vrmw_pkg::PH_WAIT_VALUE;
          end
          timeout_d = 1'b0;
        end
        if (cfg_i.low_mode != vrmw_pkg::LM_OFF) begin
          low_d = rng.lo;
        end
        if (cfg_i.high_mode != vrmw_pkg::LM_OFF) begin
          high_d = rng.hi;
        end
        if (rng.watch) begin
          summary_d = !rng.ok;
        end
        if (rng.ok) begin
          last_good_d = sample_i;
          has_good_d  = 1'b1;
          em_req      = 1'b1;
          em_good     = 1'b1;
          em_val      = sample_i;
          alarm_d     = vrmw_pkg::ALARM_NONE;
        end else begin
          alarm_d = rng.lo ? vrmw_pkg::ALARM_LOW : vrmw_pkg::ALARM_HIGH;
          if (repl_mode == vrmw_pkg::LM_LAST) begin
            em_req = has_good_q;
            em_val = last_good_q;
          end else if (repl_mode == vrmw_pkg::LM_LIMIT) begin
            em_req = 1'b1;
            em_val = rng.lo ? cfg_i.low_limit : cfg_i.high_limit;
          end
        end
      end
      vrmw_pkg::OP_TICK: begin
        if (armed) begin
          elapsed_d = elapsed_inc;
          if (tmo_on) begin
            if (phase_q == vrmw_pkg::PH_WAIT_VALUE) begin
              if (elapsed_inc > cfg_i.timeout_ticks) begin
                elapsed_d = '0;
                if (wd_reads) begin
                  rd      = 1'b1;
                  phase_d = vrmw_pkg::PH_WAIT_REPLY;
                  alarm_d = vrmw_pkg::ALARM_WAIT;
                end else begin
                  raise_alarm  = 1'b1;
                  use_fallback = (cfg_i.watchdog_mode == vrmw_pkg::WD_FALLBACK);
                  alarm_d      = vrmw_pkg::ALARM_TIMEOUT;
                end
              end
            end else if (elapsed_inc > vrmw_pkg::REPLY_TIMEOUT_TICKS) begin
              use_fallback = (cfg_i.watchdog_mode == vrmw_pkg::WD_READ_FALLB) ||
                             (cfg_i.watchdog_mode == vrmw_pkg::WD_FALLBACK);
              raise_alarm  = 1'b1;
              alarm_d      = vrmw_pkg::ALARM_WAIT;
              elapsed_d    = '0;
              phase_d      = vrmw_pkg::PH_WAIT_VALUE;
            end
          end
        end
        if (raise_alarm) begin
          summary_d = 1'b1;
          timeout_d = 1'b1;
        end
        if (use_fallback) begin
          em_req = 1'b1;
          em_val = cfg_i.fallback_value;
        end
      end
      vrmw_pkg::OP_START: begin
        if (!seen_q) begin
          if (tmo_on) begin
            elapsed_d = '0;
            if (wd_reads) begin
              phase_d = vrmw_pkg::PH_WAIT_REPLY;
              rd      = 1'b1;
              alarm_d = vrmw_pkg::ALARM_NONE;
            end else begin
              phase_d = vrmw_pkg::PH_WAIT_VALUE;
            end
          end else begin
            rd = 1'b1;
          end
        end
      end
      default: ;
    endcase

    case (cfg_i.route_mode)
      vrmw_pkg::RT_REPL_TO_INPUT: begin
        go    = !em_good;
        to_in = 1'b1;
      end
      vrmw_pkg::RT_VALID_OUT: begin
        go    = em_good;
        to_in = 1'b0;
      end
      vrmw_pkg::RT_BOTH_OUT: begin
        go    = 1'b1;
        to_in = 1'b0;
      end
      default: begin
        go    = !em_good;
        to_in = 1'b0;
      end
    endcase
    send = em_req && go;
    if (send && to_in) begin
      seen_d = 1'b1;
    end

    result_o.send_valid       = send;
    result_o.send_to_input    = send && to_in;
    result_o.sent_value       = send ? em_val : '0;
    result_o.sent_replacement = send && !em_good;
    result_o.too_low          = low_d;
    result_o.too_high         = high_d;
    result_o.summary_alarm    = summary_d;
    result_o.receive_timeout  = timeout_d;
    result_o.read_request     = rd;
    result_o.alarm_code       = alarm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= vrmw_pkg::PH_OFF;
      elapsed_q   <= '0;
      last_good_q <= '0;
      has_good_q  <= 1'b0;
      alarm_q     <= vrmw_pkg::ALARM_NONE;
      low_q       <= 1'b0;
      high_q      <= 1'b0;
      summary_q   <= 1'b0;
      timeout_q   <= 1'b0;
      seen_q      <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      last_good_q <= last_good_d;
      has_good_q  <= has_good_d;
      alarm_q     <= alarm_d;
      low_q       <= low_d;
      high_q      <= high_d;
      summary_q   <= summary_d;
      timeout_q   <= timeout_d;
      seen_q      <= seen_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/value_range_monitor_watchdog_unit.sv
// Top level of the value range monitor with receive watchdog: input register,
// result register and handshakes. Depends on vrmw_pkg, vrmw_cfg_regs and vrmw_core.
//
// Usage. Each request on the input channel (in_valid_i, in_stall_o, op_i,
// sample_i) is a received value, a one millisecond tick or a start, and gives
// exactly one result on the output channel (out_valid_o, out_stall_i and the
// result fields). A request is taken at a rising edge with in_valid_i high and
// in_stall_o low; a result is taken with out_valid_o high and out_stall_i low.
// The edge that accepts a request loads the input register; the check and
// watchdog logic loads the result register and raises out_valid_o at an edge
// at which that register is empty or its result is taken (out_stall_i low).
// Throughput is one request per cycle while the receiver does not stall.
// While the receiver stalls, the result register holds its contents, the input
// register still takes one more request, and in_stall_o then rises.
// Registers are written through cfg_valid_i, cfg_index_i and cfg_data_i; the
// port is always ready and should be written only while the block is idle.
// Reset clears configuration, flags and watchdog, which starts disabled.
`default_nettype none

module value_range_monitor_watchdog_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [1:0]                       op_i,
  input  wire logic signed [63:0]              sample_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic                             send_valid_o,
  output      logic                             send_to_input_o,
  output      logic signed [63:0]              sent_value_o,
  output      logic                             sent_replacement_o,
  output      logic                             too_low_o,
  output      logic                             too_high_o,
  output      logic                             summary_alarm_o,
  output      logic                             receive_timeout_o,
  output      logic                             read_request_o,
  output      logic [2:0]                       alarm_code_o,
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [vrmw_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [63:0]                      cfg_data_i
);

  vrmw_pkg::cfg_t    cfg;
  vrmw_pkg::result_t result;
  vrmw_pkg::result_t res_q;

  logic               s1_valid_q;
  logic [1:0]         s1_op_q;
  logic signed [63:0] s1_sample_q;
  logic               out_valid_q;
  logic               advance;
  logic               accept;

  assign cfg_ready_o = 1'b1;
  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;

  vrmw_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  vrmw_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .op_i     (s1_op_q),
    .sample_i (s1_sample_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q     <= op_i;
      s1_sample_q <= sample_i;
    end
    if (advance) begin
      res_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign send_valid_o       = res_q.send_valid;
  assign send_to_input_o    = res_q.send_to_input;
  assign sent_value_o       = res_q.sent_value;
  assign sent_replacement_o = res_q.sent_replacement;
  assign too_low_o          = res_q.too_low;
  assign too_high_o         = res_q.too_high;
  assign summary_alarm_o    = res_q.summary_alarm;
  assign receive_timeout_o  = res_q.receive_timeout;
  assign read_request_o     = res_q.read_request;
  assign alarm_code_o       = res_q.alarm_code;

endmodule

`default_nettype wire

FILE: rtl/core/vrmw_checker.sv
// Port-level checker of the value range monitor, bound to the top level.
// Depends on value_range_monitor_watchdog_unit_assert.svh for the assertion macros.
`default_nettype none
`include "value_range_monitor_watchdog_unit_assert.svh"

module vrmw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        send_valid_o,
  input wire logic        send_to_input_o,
  input wire logic [63:0] sent_value_o,
  input wire logic        sent_replacement_o,
  input wire logic        read_request_o,
  input wire logic [2:0]  alarm_code_o
);

  `VRMW_ASSERT(a_stalled_result_stays, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `VRMW_ASSERT(a_stalled_result_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(sent_value_o) && $stable(alarm_code_o))
  `VRMW_ASSERT(a_idle_send_is_clear, clk_i, rst_ni, out_valid_o && !send_valid_o |-> sent_value_o == 64'd0 && !send_to_input_o && !sent_replacement_o)
  `VRMW_ASSERT(a_valid_value_to_output, clk_i, rst_ni, out_valid_o && send_valid_o && !sent_replacement_o |-> !send_to_input_o)
  `VRMW_ASSERT_ALWAYS(a_read_without_send, clk_i, out_valid_o && read_request_o |-> !send_valid_o)

endmodule

bind value_range_monitor_watchdog_unit vrmw_checker u_vrmw_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .send_valid_o       (send_valid_o),
  .send_to_input_o    (send_to_input_o),
  .sent_value_o       (sent_value_o),
  .sent_replacement_o (sent_replacement_o),
  .read_request_o     (read_request_o),
  .alarm_code_o       (alarm_code_o)
);

`default_nettype wire
